// ===== rtl/core/nbq_pkg.sv =====
// Shared constants and a saturating add helper for the n-gram backoff query block.
`default_nettype none

package nbq_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_INSERT_DONE = 2'd1;
    localparam logic [1:0] STATUS_TABLE_FULL  = 2'd2;
    localparam logic [1:0] STATUS_UNKNOWN     = 2'd3;

    localparam logic [1:0] CFG_MODEL_ORDER = 2'd0;
    localparam logic [1:0] CFG_START_TOKEN = 2'd1;
    localparam logic [1:0] CFG_LOG_ZERO    = 2'd2;

    localparam logic [31:0] HASH_SEED = 32'h9E37_79B1;
    localparam logic [31:0] HASH_MULT = 32'h85EB_CA6B;

    localparam logic [2:0]  MODEL_ORDER_RESET = 3'd3;
    localparam logic [19:0] START_TOKEN_RESET = 20'd1;
    localparam logic [31:0] LOG_ZERO_RESET    = 32'hFF9D_0000;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            sat_add = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sat_add = s[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ngram_backoff_logprob_query.sv =====
// N-gram table with linear-probing hash lookup and backoff log probability queries.
// After reset a clearing pass writes all TABLE_ENTRIES entries before the first word is taken.
// Each lookup hashes its key one word at a time, reduces the hash to a table index, then
// probes the single table memory, each probe a read state followed by a check state.
// An insert is one lookup; a query of order n takes up to 2n-1 lookups, one word at a time.
// The result waits in output registers until m_ready; reset loads config defaults, clears counters.
`default_nettype none

module ngram_backoff_logprob_query #(
    parameter int MAX_ORDER     = 5,
    parameter int TABLE_ENTRIES = 65536,
    parameter int TOKEN_BITS    = 20
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_addr,
    input  wire logic [31:0]           cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_operation,
    input  wire logic [2:0]            s_window_length,
    input  wire logic                  s_first_position,
    input  wire logic [TOKEN_BITS-1:0] s_word_oldest,
    input  wire logic [TOKEN_BITS-1:0] s_word_back3,
    input  wire logic [TOKEN_BITS-1:0] s_word_back2,
    input  wire logic [TOKEN_BITS-1:0] s_word_back1,
    input  wire logic [TOKEN_BITS-1:0] s_word_newest,
    input  wire logic [31:0]           s_entry_logprob,
    input  wire logic [31:0]           s_entry_backoff,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [31:0]                m_result_logprob,
    output logic [2:0]                 m_matched_length,
    output logic [1:0]                 m_status
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int KEY_W   = MAX_ORDER * TOKEN_BITS;
    localparam int LEN_LO  = 1;
    localparam int KEY_LO  = 4;
    localparam int LP_LO   = 4 + KEY_W;
    localparam int BO_LO   = 36 + KEY_W;
    localparam int ENTRY_W = 68 + KEY_W;

    localparam logic [CNT_W-1:0] N_CNT   = CNT_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [2:0]       MAX_LEN = 3'(MAX_ORDER);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_HASH     = 3'd2;
    localparam logic [2:0] ST_MOD      = 3'd3;
    localparam logic [2:0] ST_PROBE_RD = 3'd4;
    localparam logic [2:0] ST_PROBE_CK = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    function automatic logic [2:0] clip_len(input logic [2:0] v);
        if (v == 3'd0) begin
            clip_len = 3'd1;
        end else if (v > MAX_LEN) begin
            clip_len = MAX_LEN;
        end else begin
            clip_len = v;
        end
    endfunction

    logic [ENTRY_W-1:0] mem [0:TABLE_ENTRIES-1];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [2:0]            state_reg, state_next;
    logic [IDX_W-1:0]      clr_idx_reg, clr_idx_next;
    logic                  op_reg, op_next;
    logic [TOKEN_BITS-1:0] win_reg [0:4];
    logic [31:0]           lp_in_reg, bo_in_reg;
    logic [2:0]            lk_len_reg, lk_len_next;
    logic                  lk_ctx_reg, lk_ctx_next;
    logic [31:0]           h_reg, h_next;
    logic [2:0]            hcnt_reg, hcnt_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      pcnt_reg, pcnt_next;
    logic [31:0]           sum_reg, sum_next;
    logic [31:0]           res_reg, res_next;
    logic [2:0]            matched_reg, matched_next;
    logic [1:0]            status_reg, status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_res_reg, out_res_next;
    logic [2:0]            out_matched_reg, out_matched_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [2:0]            model_order_reg;
    logic [19:0]           start_token_reg;
    logic [31:0]           log_zero_reg;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic                  mem_re;

    logic [TOKEN_BITS-1:0] kw [0:MAX_ORDER-1];
    logic [TOKEN_BITS-1:0] start_cmp;
    logic [51:0]           start_wide;
    logic                  accept;
    logic                  key_match;
    logic [KEY_W-1:0]      new_key;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_result_logprob = out_res_reg;
    assign m_matched_length = out_matched_reg;
    assign m_status = out_status_reg;

    assign start_wide = {32'd0, start_token_reg};
    assign start_cmp  = start_wide[TOKEN_BITS-1:0];

    always_comb begin
        logic [2:0] bi;
        for (int j = 0; j < MAX_ORDER; j++) begin
            bi = 3'(j) + {2'd0, lk_ctx_reg};
            kw[j] = (bi < 3'd5) ? win_reg[bi] : '0;
        end
    end

    always_comb begin
        key_match = rd_data_reg[0] && (rd_data_reg[LEN_LO +: 3] == lk_len_reg);
        for (int j = 0; j < MAX_ORDER; j++) begin
            if ((3'(j) < lk_len_reg) &&
                (rd_data_reg[KEY_LO + j*TOKEN_BITS +: TOKEN_BITS] != kw[j])) begin
                key_match = 1'b0;
            end
        end
        for (int j = 0; j < MAX_ORDER; j++) begin
            new_key[j*TOKEN_BITS +: TOKEN_BITS] = (3'(j) < lk_len_reg) ? kw[j] : '0;
        end
    end

    always_comb begin
        logic [2:0]        qlen;
        logic [2:0]        hb;
        logic [31:0]       hx;
        logic [31:0]       hp;
        logic [IDX_W:0]    shifted;
        logic              hit;
        logic              free_slot;
        logic              decided;

        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        op_next          = op_reg;
        lk_len_next      = lk_len_reg;
        lk_ctx_next      = lk_ctx_reg;
        h_next           = h_reg;
        hcnt_next        = hcnt_reg;
        idx_next         = idx_reg;
        pcnt_next        = pcnt_reg;
        sum_next         = sum_reg;
        res_next         = res_reg;
        matched_next     = matched_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_res_next     = out_res_reg;
        out_matched_next = out_matched_reg;
        out_status_next  = out_status_reg;
        used_next        = used_reg;
        mem_we           = 1'b0;
        mem_waddr        = clr_idx_reg;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        qlen             = 3'd1;
        hb               = '0;
        hx               = '0;
        hp               = '0;
        shifted          = '0;
        hit              = 1'b0;
        free_slot        = 1'b0;
        decided          = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    op_next      = s_operation;
                    sum_next     = '0;
                    res_next     = '0;
                    matched_next = '0;
                    status_next  = nbq_pkg::STATUS_OK;
                    qlen         = clip_len(s_window_length);
                    if (s_operation == nbq_pkg::OP_QUERY) begin
                        if (clip_len(model_order_reg) < qlen) begin
                            qlen = clip_len(model_order_reg);
                        end
                    end
                    lk_len_next = qlen;
                    lk_ctx_next = 1'b0;
                    h_next      = {29'd0, qlen} * nbq_pkg::HASH_SEED;
                    hcnt_next   = qlen;
                    state_next  = ST_HASH;
                    if (s_operation == nbq_pkg::OP_QUERY) begin
                        if (s_first_position) begin
                            res_next   = (s_word_newest == start_cmp) ? 32'd0 : log_zero_reg;
                            state_next = ST_DONE;
                        end else if (s_word_newest == start_cmp) begin
                            res_next   = log_zero_reg;
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_HASH: begin
                hb        = hcnt_reg - 3'd1 + {2'd0, lk_ctx_reg};
                hx        = h_reg ^ ((hb < 3'd5) ? 32'(win_reg[hb]) : 32'd0);
                hp        = hx * nbq_pkg::HASH_MULT;
                h_next    = hp ^ (hp >> 13);
                hcnt_next = hcnt_reg - 3'd1;
                if (hcnt_reg == 3'd1) begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                // The low index bits stay below twice the table size, so one subtraction folds them.
                shifted = {1'b0, h_reg[IDX_W-1:0]};
                if (shifted >= N_CNT) begin
                    shifted = shifted - N_CNT;
                end
                idx_next   = shifted[IDX_W-1:0];
                pcnt_next  = '0;
                state_next = ST_PROBE_RD;
            end
            ST_PROBE_RD: begin
                mem_re     = 1'b1;
                state_next = ST_PROBE_CK;
            end
            ST_PROBE_CK: begin
                if (!rd_data_reg[0]) begin
                    free_slot = 1'b1;
                    decided   = 1'b1;
                end else if (key_match) begin
                    hit     = 1'b1;
                    decided = 1'b1;
                end else if (pcnt_reg == N_CNT - 1'b1) begin
                    decided = 1'b1;
                end else begin
                    idx_next   = (idx_reg == LAST_IX) ? '0 : idx_reg + 1'b1;
                    pcnt_next  = pcnt_reg + 1'b1;
                    state_next = ST_PROBE_RD;
                end
                if (decided) begin
                    mem_waddr = idx_reg;
                    if (op_reg == nbq_pkg::OP_INSERT) begin
                        res_next     = '0;
                        matched_next = '0;
                        state_next   = ST_DONE;
                        if (hit) begin
                            mem_we      = 1'b1;
                            mem_wdata   = {bo_in_reg, lp_in_reg,
                                           rd_data_reg[KEY_LO +: KEY_W],
                                           rd_data_reg[LEN_LO +: 3], 1'b1};
                            status_next = nbq_pkg::STATUS_INSERT_DONE;
                        end else if (free_slot && (used_reg < N_CNT)) begin
                            mem_we      = 1'b1;
                            mem_wdata   = {bo_in_reg, lp_in_reg, new_key, lk_len_reg, 1'b1};
                            used_next   = used_reg + 1'b1;
                            status_next = nbq_pkg::STATUS_INSERT_DONE;
                        end else begin
                            status_next = nbq_pkg::STATUS_TABLE_FULL;
                        end
                    end else if (!lk_ctx_reg) begin
                        if (hit) begin
                            res_next     = nbq_pkg::sat_add(sum_reg, rd_data_reg[LP_LO +: 32]);
                            matched_next = lk_len_reg;
                            status_next  = nbq_pkg::STATUS_OK;
                            state_next   = ST_DONE;
                        end else if (lk_len_reg <= 3'd1) begin
                            res_next     = log_zero_reg;
                            matched_next = '0;
                            status_next  = nbq_pkg::STATUS_UNKNOWN;
                            state_next   = ST_DONE;
                        end else begin
                            lk_len_next = lk_len_reg - 3'd1;
                            lk_ctx_next = 1'b1;
                            h_next      = {29'd0, lk_len_reg - 3'd1} * nbq_pkg::HASH_SEED;
                            hcnt_next   = lk_len_reg - 3'd1;
                            state_next  = ST_HASH;
                        end
                    end else begin
                        if (hit) begin
                            sum_next = nbq_pkg::sat_add(sum_reg, rd_data_reg[BO_LO +: 32]);
                        end
                        lk_ctx_next = 1'b0;
                        h_next      = {29'd0, lk_len_reg} * nbq_pkg::HASH_SEED;
                        hcnt_next   = lk_len_reg;
                        state_next  = ST_HASH;
                    end
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next   = 1'b1;
                    out_res_next     = res_reg;
                    out_matched_next = matched_reg;
                    out_status_next  = status_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
            used_reg        <= '0;
            model_order_reg <= nbq_pkg::MODEL_ORDER_RESET;
            start_token_reg <= nbq_pkg::START_TOKEN_RESET;
            log_zero_reg    <= nbq_pkg::LOG_ZERO_RESET;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
            used_reg      <= used_next;
            if (cfg_we) begin
                case (cfg_addr)
                    nbq_pkg::CFG_MODEL_ORDER: model_order_reg <= cfg_wdata[2:0];
                    nbq_pkg::CFG_START_TOKEN: start_token_reg <= cfg_wdata[19:0];
                    nbq_pkg::CFG_LOG_ZERO:    log_zero_reg    <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        lk_len_reg      <= lk_len_next;
        lk_ctx_reg      <= lk_ctx_next;
        h_reg           <= h_next;
        hcnt_reg        <= hcnt_next;
        idx_reg         <= idx_next;
        pcnt_reg        <= pcnt_next;
        sum_reg         <= sum_next;
        res_reg         <= res_next;
        matched_reg     <= matched_next;
        status_reg      <= status_next;
        out_res_reg     <= out_res_next;
        out_matched_reg <= out_matched_next;
        out_status_reg  <= out_status_next;
        if (accept) begin
            win_reg[0] <= s_word_newest;
            win_reg[1] <= s_word_back1;
            win_reg[2] <= s_word_back2;
            win_reg[3] <= s_word_back3;
            win_reg[4] <= s_word_oldest;
            lp_in_reg  <= s_entry_logprob;
            bo_in_reg  <= s_entry_backoff;
        end
    end

    a_used_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= N_CNT)
        else $error("Entry count exceeds the table size.");

    a_used_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_CLEAR |=> used_reg >= $past(used_reg))
        else $error("Entry count decreased.");

    a_insert_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == nbq_pkg::STATUS_INSERT_DONE ||
                    m_status == nbq_pkg::STATUS_TABLE_FULL)
        |-> m_result_logprob == 32'd0 && m_matched_length == 3'd0)
        else $error("Insert word carries a query result.");

    a_unknown_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == nbq_pkg::STATUS_UNKNOWN |-> m_matched_length == 3'd0)
        else $error("Unknown word reports a matched length.");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR || state_reg == ST_PROBE_CK |-> !s_ready)
        else $error("Input taken while a lookup or the clearing pass runs.");

endmodule

`default_nettype wire
